/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file tsls_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSLS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TSLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/tsls_pkg.sv */
package tsls_pkg;

  localparam int ID_W    = 8;
  localparam int COORD_W = 16;
  localparam int LEN_W   = 31;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic sq_en;
    logic root_step;
    logic acc_clear;
    logic acc_add;
    logic best_take;
    logic best_clear;
    logic out_load;
    logic out_last;
  } tsls_cmd_t;

  typedef struct packed {
    logic better;
  } tsls_stat_t;

endpackage

/* hw/rtl/tsls_if.sv */
interface tsls_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsls_pkg::ID_W-1:0]   city_id;
  logic signed [tsls_pkg::COORD_W-1:0] x_coord;
  logic signed [tsls_pkg::COORD_W-1:0] y_coord;
  logic                        last_city;
  modport source (output valid, city_id, x_coord, y_coord, last_city, input ready);
  modport sink (input valid, city_id, x_coord, y_coord, last_city, output ready);
endinterface

interface tsls_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsls_pkg::ID_W-1:0]   out_city_id;
  logic [tsls_pkg::LEN_W-1:0]  tour_length;
  logic                        out_last;
  modport source (output valid, out_city_id, tour_length, out_last, input ready);
  modport sink (input valid, out_city_id, tour_length, out_last, output ready);
endinterface

/* hw/rtl/tsp_swap_local_search_unit.sv */
// channel  dir  beat
// in_ch    in   one tour position: city_id, x_coord, y_coord, last_city
// out_ch   out  one position of the best swap neighbour: out_city_id, tour_length, out_last
//
// loading takes one beat per cycle; the last beat starts the swap search, or emit for one city
// search of an n-city tour: each swap i < j sums all tour edges by read, square, the
// bit-serial square root and accumulate, then evaluate; emit reads, loads, offers a beat
// no input beat is taken from the last beat until the last result beat leaves
// reset clears the controller and best_len; the position stores need no clearing
module tsp_swap_local_search_unit #(
  parameter int MAX_CITIES = 64,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  tsls_in_if.sink    in_ch,
  tsls_out_if.source out_ch
);
  import tsls_pkg::*;

  localparam int AW     = $clog2(MAX_CITIES);
  localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;

  tsls_cmd_t     cmd;
  tsls_stat_t    stat;
  logic [AW-1:0] wr_addr, rd_a, rd_b;

  tsls_ctrl #(
    .MAX_CITIES(MAX_CITIES),
    .ROOT_W    (ROOT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_city),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  tsls_dp #(
    .MAX_CITIES(MAX_CITIES),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .wr_addr (wr_addr),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .in_id   (in_ch.city_id),
    .in_x    (in_ch.x_coord),
    .in_y    (in_ch.y_coord),
    .out_id  (out_ch.out_city_id),
    .out_len (out_ch.tour_length),
    .out_last(out_ch.out_last)
  );

endmodule

/* hw/rtl/tsls_dp.sv */
module tsls_dp #(
  parameter int MAX_CITIES = 64,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tsls_pkg::tsls_cmd_t                 cmd,
  output tsls_pkg::tsls_stat_t                stat,
  input  logic [$clog2(MAX_CITIES)-1:0]       wr_addr,
  input  logic [$clog2(MAX_CITIES)-1:0]       rd_a,
  input  logic [$clog2(MAX_CITIES)-1:0]       rd_b,
  input  logic [tsls_pkg::ID_W-1:0]           in_id,
  input  logic [tsls_pkg::COORD_W-1:0]        in_x,
  input  logic [tsls_pkg::COORD_W-1:0]        in_y,
  output logic [tsls_pkg::ID_W-1:0]           out_id,
  output logic [tsls_pkg::LEN_W-1:0]          out_len,
  output logic                                out_last
);
  import tsls_pkg::*;

  localparam int AW     = $clog2(MAX_CITIES);
  localparam int C      = COORD_BITS;
  localparam int RAD_W  = 2 * C + 2 + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SUM_W  = (ROOT_W + AW + 1 > 32) ? ROOT_W + AW + 1 : 32;

  logic [ID_W-1:0] id_mem [MAX_CITIES];
  logic [C-1:0]    x_mem  [MAX_CITIES];
  logic [C-1:0]    y_mem  [MAX_CITIES];

  logic [C-1:0]    xa, ya, xb, yb;
  logic [ID_W-1:0] ida;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      id_mem[wr_addr] <= in_id;
      x_mem[wr_addr]  <= in_x[C-1:0];
      y_mem[wr_addr]  <= in_y[C-1:0];
    end
    if (cmd.rd_en) begin
      xa  <= x_mem[rd_a];
      ya  <= y_mem[rd_a];
      xb  <= x_mem[rd_b];
      yb  <= y_mem[rd_b];
      ida <= id_mem[rd_a];
    end
  end

  logic signed [C:0] dx, dy;
  logic [C-1:0]      ax, ay;
  logic [2*C-1:0]    sqx, sqy;
  logic [2*C:0]      sumsq;

  always_comb begin
    dx    = $signed({xa[C-1], xa}) - $signed({xb[C-1], xb});
    dy    = $signed({ya[C-1], ya}) - $signed({yb[C-1], yb});
    ax    = dx[C] ? C'(-dx) : dx[C-1:0];
    ay    = dy[C] ? C'(-dy) : dy[C-1:0];
    sqx   = ax * ax;
    sqy   = ay * ay;
    sumsq = {1'b0, sqx} + {1'b0, sqy};
  end

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      rad  <= RAD_W'(sumsq) << (2 * FRAC_BITS);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  logic [SUM_W-1:0] acc;
  logic [LEN_W-1:0] cost;
  logic [LEN_W-1:0] best_len;

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + SUM_W'(root);
    end
  end

  always_comb begin
    cost        = (acc > SUM_W'(LEN_MAX)) ? LEN_MAX : acc[LEN_W-1:0];
    stat.better = cost < best_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_len <= '0;
    end else if (cmd.best_clear) begin
      best_len <= '0;
    end else if (cmd.best_take) begin
      best_len <= cost;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id   <= ida;
      out_last <= cmd.out_last;
    end
  end

  assign out_len = best_len;

endmodule

/* hw/rtl/tsls_ctrl.sv */
module tsls_ctrl #(
  parameter int MAX_CITIES = 64,
  parameter int ROOT_W     = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_last,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  tsls_pkg::tsls_stat_t            stat,
  output tsls_pkg::tsls_cmd_t             cmd,
  output logic [$clog2(MAX_CITIES)-1:0]   wr_addr,
  output logic [$clog2(MAX_CITIES)-1:0]   rd_a,
  output logic [$clog2(MAX_CITIES)-1:0]   rd_b
);
  import tsls_pkg::*;

  localparam int AW = $clog2(MAX_CITIES);
  localparam int CW = $clog2(MAX_CITIES + 1);
  localparam int KW = $clog2(ROOT_W + 1);

  typedef enum logic [8:0] {
    ST_LOAD  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_SQ    = 9'b000000100,
    ST_ROOT  = 9'b000001000,
    ST_ACC   = 9'b000010000,
    ST_EVAL  = 9'b000100000,
    ST_E_RD  = 9'b001000000,
    ST_E_LD  = 9'b010000000,
    ST_E_OUT = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] swap_pos(input logic [AW-1:0] q, input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    if (q == a) return b;
    if (q == b) return a;
    return q;
  endfunction

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] n, n_next;
  logic [AW-1:0] i, i_next, j, j_next, p, p_next;
  logic [AW-1:0] bf, bf_next, bs, bs_next;
  logic [KW-1:0] k, k_next;
  logic          room, p_end, first;
  logic [CW-1:0] n_load;

  always_comb begin
    room   = cnt < CW'(MAX_CITIES);
    n_load = room ? cnt + CW'(1) : cnt;
    p_end  = CW'(p) == n - CW'(1);
    first  = (i == '0) && (j == AW'(1));
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    n_next     = n;
    i_next     = i;
    j_next     = j;
    p_next     = p;
    bf_next    = bf;
    bs_next    = bs;
    k_next     = k;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    wr_addr    = cnt[AW-1:0];
    rd_a       = swap_pos(p, i, j);
    rd_b       = p_end ? swap_pos('0, i, j) : swap_pos(p + AW'(1), i, j);
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en = room;
          cnt_next  = n_load;
          if (in_last) begin
            n_next        = n_load;
            i_next        = '0;
            j_next        = AW'(1);
            p_next        = '0;
            bf_next       = '0;
            bs_next       = '0;
            cmd.acc_clear = 1'b1;
            if (n_load == CW'(1)) begin
              cmd.best_clear = 1'b1;
              state_next     = ST_E_RD;
            end else begin
              state_next = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_en  = 1'b1;
        k_next     = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        k_next        = k + KW'(1);
        if (k == KW'(ROOT_W - 1)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        if (p_end) begin
          state_next = ST_EVAL;
        end else begin
          p_next     = p + AW'(1);
          state_next = ST_RD;
        end
      end
      ST_EVAL: begin
        cmd.acc_clear = 1'b1;
        p_next        = '0;
        if (first || stat.better) begin
          cmd.best_take = 1'b1;
          bf_next       = i;
          bs_next       = j;
        end
        if (CW'(j) == n - CW'(1)) begin
          if (CW'(i) == n - CW'(2)) begin
            state_next = ST_E_RD;
          end else begin
            i_next     = i + AW'(1);
            j_next     = i + AW'(2);
            state_next = ST_RD;
          end
        end else begin
          j_next     = j + AW'(1);
          state_next = ST_RD;
        end
      end
      ST_E_RD: begin
        rd_a       = swap_pos(p, bf, bs);
        cmd.rd_en  = 1'b1;
        state_next = ST_E_LD;
      end
      ST_E_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = p_end;
        state_next   = ST_E_OUT;
      end
      ST_E_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (p_end) begin
            cnt_next   = '0;
            state_next = ST_LOAD;
          end else begin
            p_next     = p + AW'(1);
            state_next = ST_E_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      p     <= '0;
      bf    <= '0;
      bs    <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
      p     <= p_next;
      bf    <= bf_next;
      bs    <= bs_next;
      k     <= k_next;
    end
  end

endmodule

/* hw/rtl/tsls_checker.sv */
`include "assert_macros.svh"

module tsls_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_last,
  input logic [tsls_pkg::LEN_W-1:0]  tour_length
);

  `TSLS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TSLS_ASSERT_NOW(a_no_load_while_out, clk, rst, out_valid, !in_ready)
  `TSLS_ASSERT_NEXT(a_len_stable, clk, rst, out_valid && out_ready && !out_last, $stable(tour_length))
  `TSLS_ASSERT_NEXT(a_ready_after_last, clk, rst, out_valid && out_ready && out_last, in_ready)
  `TSLS_ASSERT_NEXT(a_busy_after_last_in, clk, rst, in_valid && in_ready && in_last, !in_ready)

endmodule

bind tsp_swap_local_search_unit tsls_checker u_tsls_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_city),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_last   (out_ch.out_last),
  .tour_length(out_ch.tour_length)
);
